// File: rtl/sdsg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and tables of the sine DAC sample generator.
// No dependencies; used by every module of the block.
package sdsg_pkg;

  // Block constants
  localparam int MAX_SAMPLES     = 1024;
  localparam int DAC_MAX         = 4095;
  localparam int CORDIC_STAGES   = 16;
  localparam int ATAN_ENTRIES    = 24;
  localparam int CORDIC_N        = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;
  localparam int TURN_SIXTEENTHS = 5760;

  // Field and register widths
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int ANG_W     = 14;
  localparam int AMP_W     = 13;
  localparam int OFF_W     = 14;
  localparam int DAC_W     = 12;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;

  // Phase arithmetic: n = start*cnt + (end-start)*idx, denominator cnt*5760
  localparam int DIFF_W   = ANG_W + 1;
  localparam int PROD_W   = 26;
  localparam int TURN_W   = $clog2(TURN_SIXTEENTHS + 1);
  localparam int DEN_W    = CNT_W + TURN_W;
  localparam int REM_W    = DEN_W + 4;
  localparam int SUM_W    = REM_W + 1;
  localparam int BAM_W    = 32;

  // Range reduction: |n| < 5*den always, so n + 5*den lies in [0, 16*den)
  localparam int PRE_CELLS = 4;
  localparam int DIV_CELLS = PRE_CELLS + BAM_W;

  // CORDIC datapath
  localparam int XY_W       = BAM_W + 1;
  localparam int SHIFT_W    = $clog2(ATAN_ENTRIES);
  localparam int FRAC_W     = 15;
  localparam int SINE_W     = FRAC_W + 1;
  localparam int SINE_SUM_W = XY_W + 1;
  localparam int MUL_W      = AMP_W + SINE_W;
  localparam int ACC_W      = MUL_W + 2;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

  localparam logic [BAM_W-1:0] ATAN_BAM [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE    = 3'd0,
    CFG_DC_OFFSET    = 3'd1,
    CFG_START_ANGLE  = 3'd2,
    CFG_END_ANGLE    = 3'd3,
    CFG_SAMPLE_COUNT = 3'd4
  } cfg_reg_e;

  // One slot of the divider chain
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic [REM_W-1:0] rem;
    logic [BAM_W-1:0] quo;
  } div_t;

  // One slot of the CORDIC chain
  typedef struct packed {
    logic                   valid;
    logic [IDX_W-1:0]       idx;
    logic                   neg;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } cordic_t;

endpackage

// File: rtl/sdsg_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: compare-subtract, one quotient bit per cycle while en_i is high.
// Depends on sdsg_pkg.
module sdsg_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         shift_en_i,
  input  logic [sdsg_pkg::REM_W-1:0]   den_i,
  input  sdsg_pkg::div_t               cell_i,
  output sdsg_pkg::div_t               cell_o
);

  logic                       fits;
  logic [sdsg_pkg::REM_W-1:0] diff;
  logic [sdsg_pkg::REM_W-1:0] rem_new;
  sdsg_pkg::div_t             cell_d;
  sdsg_pkg::div_t             cell_q;

  always_comb begin
    fits    = (cell_i.rem >= den_i);
    diff    = fits ? (cell_i.rem - den_i) : cell_i.rem;
    rem_new = shift_en_i ? {diff[sdsg_pkg::REM_W-2:0], 1'b0} : diff;
    cell_d       = cell_i;
    cell_d.rem   = rem_new;
    cell_d.quo   = {cell_i.quo[sdsg_pkg::BAM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/sdsg_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation cell: rotate toward z = 0 by atan(2^-k).
// Depends on sdsg_pkg.
module sdsg_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [sdsg_pkg::SHIFT_W-1:0]  shift_i,
  input  logic [sdsg_pkg::BAM_W-1:0]    atan_i,
  input  sdsg_pkg::cordic_t             cell_i,
  output sdsg_pkg::cordic_t             cell_o
);

  logic signed [sdsg_pkg::XY_W-1:0] xs;
  logic signed [sdsg_pkg::XY_W-1:0] ys;
  logic signed [sdsg_pkg::XY_W-1:0] ang;
  sdsg_pkg::cordic_t                cell_d;
  sdsg_pkg::cordic_t                cell_q;

  always_comb begin
    xs     = cell_i.x >>> shift_i;
    ys     = cell_i.y >>> shift_i;
    ang    = signed'({1'b0, atan_i});
    cell_d = cell_i;
    if (!cell_i.z[sdsg_pkg::XY_W-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: rtl/sine_dac_sample_generator.sv
`timescale 1ns / 1ps
// Sine DAC sample generator, top level. Throughput: one sample per cycle unless the
// output is stalled, set by the fully pipelined divider and CORDIC cell rows.
// Reset: registers take amplitude 1842, offset 2047, angles 0..5760, count 1024; pipe empties.
// Depends on sdsg_pkg, sdsg_div_cell and sdsg_cordic_cell.
module sine_dac_sample_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sdsg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sdsg_pkg::CFG_W-1:0]      cfg_wdata_i,
  // sample index channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sdsg_pkg::IDX_W-1:0]      sample_index_i,
  // DAC result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sdsg_pkg::DAC_W-1:0]      dac_value_o,
  output logic [sdsg_pkg::IDX_W-1:0]      echo_index_o,
  output logic                            was_clamped_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::AMP_W-1:0] amp_q;
  logic signed [sdsg_pkg::OFF_W-1:0] off_q;
  logic signed [sdsg_pkg::ANG_W-1:0] start_q;
  logic signed [sdsg_pkg::ANG_W-1:0] end_q;
  logic [sdsg_pkg::CNT_W-1:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q   <= 13'sd1842;
      off_q   <= 14'sd2047;
      start_q <= 14'sd0;
      end_q   <= 14'sd5760;
      cnt_q   <= 11'd1024;
    end else if (cfg_we_i) begin
      unique case (sdsg_pkg::cfg_reg_e'(cfg_index_i))
        sdsg_pkg::CFG_AMPLITUDE:    amp_q   <= signed'(cfg_wdata_i[sdsg_pkg::AMP_W-1:0]);
        sdsg_pkg::CFG_DC_OFFSET:    off_q   <= signed'(cfg_wdata_i[sdsg_pkg::OFF_W-1:0]);
        sdsg_pkg::CFG_START_ANGLE:  start_q <= signed'(cfg_wdata_i[sdsg_pkg::ANG_W-1:0]);
        sdsg_pkg::CFG_END_ANGLE:    end_q   <= signed'(cfg_wdata_i[sdsg_pkg::ANG_W-1:0]);
        sdsg_pkg::CFG_SAMPLE_COUNT: cnt_q   <= cfg_wdata_i[sdsg_pkg::CNT_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Effective count: zero acts as one, large counts saturate at the table size.
  logic [sdsg_pkg::CNT_W-1:0]    cnt_eff;
  logic [sdsg_pkg::CNT_W-1:0]    cnt_last;
  logic [sdsg_pkg::DEN_W-1:0]    den;
  logic [sdsg_pkg::DEN_W+2:0]    five_den;
  logic [sdsg_pkg::REM_W-1:0]    den_rem;

  always_comb begin
    if (cnt_q == '0) begin
      cnt_eff = sdsg_pkg::CNT_W'(1);
    end else if (int'(cnt_q) > sdsg_pkg::MAX_SAMPLES) begin
      cnt_eff = sdsg_pkg::CNT_W'(sdsg_pkg::MAX_SAMPLES);
    end else begin
      cnt_eff = cnt_q;
    end
  end

  assign cnt_last = cnt_eff - sdsg_pkg::CNT_W'(1);
  // Denominator of the phase fraction: one full turn per count.
  assign den      = sdsg_pkg::DEN_W'(cnt_eff) * sdsg_pkg::DEN_W'(sdsg_pkg::TURN_SIXTEENTHS);
  assign five_den = {1'b0, den, 2'b00} + {3'b000, den};
  assign den_rem  = {{(sdsg_pkg::REM_W - sdsg_pkg::DEN_W){1'b0}}, den};

  // ---------------------------------------------------------------------------
  // Pipeline advance and input skid register
  // The whole row advances unless a finished result is held at the output.
  // The skid register still takes one transfer while the row is held.
  // ---------------------------------------------------------------------------
  logic                       pipe_en;
  logic                       skid_full_q;
  logic [sdsg_pkg::IDX_W-1:0] skid_idx_q;
  logic                       in_xfer;
  logic                       out_valid_q;

  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_stall_o = skid_full_q;
  assign in_xfer    = in_valid_i && !skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (pipe_en) begin
      skid_full_q <= 1'b0;
    end else if (in_xfer) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!pipe_en && in_xfer) begin
      skid_idx_q <= sample_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: select source and limit the index to count-1
  // ---------------------------------------------------------------------------
  logic                       sel_valid;
  logic [sdsg_pkg::IDX_W-1:0] sel_idx;
  logic [sdsg_pkg::IDX_W-1:0] idx_lim;
  logic                       s1_valid_q;
  logic [sdsg_pkg::IDX_W-1:0] s1_idx_q;

  assign sel_valid = skid_full_q || in_valid_i;
  assign sel_idx   = skid_full_q ? skid_idx_q : sample_index_i;
  assign idx_lim   = ({1'b0, sel_idx} > cnt_last) ? cnt_last[sdsg_pkg::IDX_W-1:0] : sel_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_q <= sel_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_idx_q <= idx_lim;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the two phase products
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::DIFF_W-1:0] ang_diff;
  logic signed [sdsg_pkg::PROD_W-1:0] pa_d;
  logic signed [sdsg_pkg::PROD_W-1:0] pb_d;
  logic signed [sdsg_pkg::PROD_W-1:0] s2_pa_q;
  logic signed [sdsg_pkg::PROD_W-1:0] s2_pb_q;
  logic                               s2_valid_q;
  logic [sdsg_pkg::IDX_W-1:0]         s2_idx_q;

  assign ang_diff = sdsg_pkg::DIFF_W'(end_q) - sdsg_pkg::DIFF_W'(start_q);
  assign pa_d = sdsg_pkg::PROD_W'(start_q) * sdsg_pkg::PROD_W'(signed'({1'b0, cnt_eff}));
  assign pb_d = sdsg_pkg::PROD_W'(ang_diff) * sdsg_pkg::PROD_W'(signed'({1'b0, s1_idx_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_pa_q  <= pa_d;
      s2_pb_q  <= pb_d;
      s2_idx_q <= s1_idx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: bias the numerator by five denominators so it is never negative.
  // Whole turns drop out of the binary angle, so the bias leaves it unchanged.
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::SUM_W-1:0] num_d;
  sdsg_pkg::div_t                    div_pipe [sdsg_pkg::DIV_CELLS+1];

  assign num_d = sdsg_pkg::SUM_W'(s2_pa_q) + sdsg_pkg::SUM_W'(s2_pb_q)
               + sdsg_pkg::SUM_W'(signed'({1'b0, five_den}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pipe[0] <= '0;
    end else if (pipe_en) begin
      div_pipe[0].valid <= s2_valid_q;
      div_pipe[0].idx   <= s2_idx_q;
      div_pipe[0].rem   <= num_d[sdsg_pkg::REM_W-1:0];
      div_pipe[0].quo   <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider row: four reduction cells (8, 4, 2, 1 times den) leave n mod den,
  // then one cell per bit of the 32-bit binary angle, MSB first.
  // ---------------------------------------------------------------------------
  for (genvar c = 0; c < sdsg_pkg::DIV_CELLS; c++) begin : g_div
    localparam int SH = (c < sdsg_pkg::PRE_CELLS) ? (sdsg_pkg::PRE_CELLS - 1 - c) : 0;
    sdsg_div_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (pipe_en),
      .shift_en_i (c >= sdsg_pkg::PRE_CELLS - 1),
      .den_i      (den_rem << SH),
      .cell_i     (div_pipe[c]),
      .cell_o     (div_pipe[c+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Fold into -90..+90 degrees and seed the CORDIC row
  // ---------------------------------------------------------------------------
  logic [sdsg_pkg::BAM_W-1:0] bam;
  logic                       fold;
  sdsg_pkg::cordic_t          cor_pipe [sdsg_pkg::CORDIC_N+1];

  assign bam  = div_pipe[sdsg_pkg::DIV_CELLS].quo;
  assign fold = bam[sdsg_pkg::BAM_W-1] ^ bam[sdsg_pkg::BAM_W-2];

  always_comb begin
    cor_pipe[0].valid = div_pipe[sdsg_pkg::DIV_CELLS].valid;
    cor_pipe[0].idx   = div_pipe[sdsg_pkg::DIV_CELLS].idx;
    cor_pipe[0].neg   = fold;
    cor_pipe[0].x     = sdsg_pkg::CORDIC_X0;
    cor_pipe[0].y     = '0;
    // Adding half a turn only flips the top bit.
    cor_pipe[0].z     = signed'({bam[sdsg_pkg::BAM_W-1] ^ fold,
                                 bam[sdsg_pkg::BAM_W-1] ^ fold,
                                 bam[sdsg_pkg::BAM_W-2:0]});
  end

  for (genvar k = 0; k < sdsg_pkg::CORDIC_N; k++) begin : g_cordic
    sdsg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .shift_i (sdsg_pkg::SHIFT_W'(k)),
      .atan_i  (sdsg_pkg::ATAN_BAM[k]),
      .cell_i  (cor_pipe[k]),
      .cell_o  (cor_pipe[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sine stage: round y to Q1.15, saturate, apply the fold negation
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::SINE_SUM_W-1:0] y_rnd;
  logic signed [sdsg_pkg::SINE_SUM_W-1:0] y_sh;
  logic signed [sdsg_pkg::SINE_W-1:0]     s_sat;
  logic signed [sdsg_pkg::SINE_W-1:0]     sine_d;
  logic signed [sdsg_pkg::SINE_W-1:0]     sine_q;
  logic                                   sine_valid_q;
  logic [sdsg_pkg::IDX_W-1:0]             sine_idx_q;

  assign y_rnd = sdsg_pkg::SINE_SUM_W'(cor_pipe[sdsg_pkg::CORDIC_N].y)
               + sdsg_pkg::SINE_SUM_W'(16384);
  assign y_sh  = y_rnd >>> sdsg_pkg::FRAC_W;

  always_comb begin
    if (y_sh > sdsg_pkg::SINE_SUM_W'(32767)) begin
      s_sat = 16'sh7FFF;
    end else if (y_sh < sdsg_pkg::SINE_SUM_W'(-32768)) begin
      s_sat = 16'sh8000;
    end else begin
      s_sat = y_sh[sdsg_pkg::SINE_W-1:0];
    end
    if (!cor_pipe[sdsg_pkg::CORDIC_N].neg) begin
      sine_d = s_sat;
    end else if (s_sat == 16'sh8000) begin
      sine_d = 16'sh7FFF;  // negated full scale saturates
    end else begin
      sine_d = -s_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_valid_q <= 1'b0;
    end else if (pipe_en) begin
      sine_valid_q <= cor_pipe[sdsg_pkg::CORDIC_N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sine_q     <= sine_d;
      sine_idx_q <= cor_pipe[sdsg_pkg::CORDIC_N].idx;
    end
  end

  // ---------------------------------------------------------------------------
  // Scale stage: amplitude times sine
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::MUL_W-1:0] mul_q;
  logic                              mul_valid_q;
  logic [sdsg_pkg::IDX_W-1:0]        mul_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (pipe_en) begin
      mul_valid_q <= sine_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mul_q     <= sdsg_pkg::MUL_W'(amp_q) * sdsg_pkg::MUL_W'(sine_q);
      mul_idx_q <= sine_idx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: add offset, truncate toward zero, limit to 0..DAC_MAX
  // ---------------------------------------------------------------------------
  logic signed [sdsg_pkg::ACC_W-1:0] acc;
  logic signed [sdsg_pkg::ACC_W-1:0] acc_sh;
  logic signed [sdsg_pkg::ACC_W-1:0] val;
  logic [sdsg_pkg::DAC_W-1:0]        dac_d;
  logic                              clamp_d;
  logic [sdsg_pkg::DAC_W-1:0]        dac_q;
  logic [sdsg_pkg::IDX_W-1:0]        out_idx_q;
  logic                              clamp_q;

  assign acc    = sdsg_pkg::ACC_W'(mul_q) + (sdsg_pkg::ACC_W'(off_q) <<< sdsg_pkg::FRAC_W);
  assign acc_sh = acc >>> sdsg_pkg::FRAC_W;
  // Arithmetic shift floors; bump negative values with a remainder back toward zero.
  assign val    = (acc[sdsg_pkg::ACC_W-1] && (acc[sdsg_pkg::FRAC_W-1:0] != '0))
                ? acc_sh + sdsg_pkg::ACC_W'(1) : acc_sh;

  always_comb begin
    if (val[sdsg_pkg::ACC_W-1]) begin
      dac_d   = '0;
      clamp_d = 1'b1;
    end else if (val > sdsg_pkg::ACC_W'(sdsg_pkg::DAC_MAX)) begin
      dac_d   = sdsg_pkg::DAC_W'(sdsg_pkg::DAC_MAX);
      clamp_d = 1'b1;
    end else begin
      dac_d   = val[sdsg_pkg::DAC_W-1:0];
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= mul_valid_q;
    end
  end

  // Hold the result while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dac_q     <= dac_d;
      out_idx_q <= mul_idx_q;
      clamp_q   <= clamp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dac_value_o   = dac_q;
  assign echo_index_o  = out_idx_q;
  assign was_clamped_o = clamp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A held skid entry drains into the row as soon as the row advances.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && pipe_en |=> !skid_full_q)
    else $error("skid entry not drained on advance");

  // A transfer taken while the row is held lands in the skid register.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en && in_valid_i && !in_stall_o |=> skid_full_q)
    else $error("transfer during hold not captured");

  // A scaled sample moves into the output register on advance.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && mul_valid_q |=> out_valid_o)
    else $error("result lost before output register");

endmodule

// File: sim/sine_dac_sample_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sine_dac_sample_generator: directed table, then random phases.
// Depends on sdsg_pkg and the RTL of the block; expected codes come from a local CORDIC model.
module sine_dac_sample_generator_tb;
  import sdsg_pkg::*;

  // Behavior constants of the block, kept locally for the predictor
  localparam longint SAMPLES_CAP = 1024;
  localparam longint DAC_TOP     = 4095;
  localparam int     ROT_STAGES  = 16;
  localparam longint TURN        = 5760;
  localparam longint GAIN_X0     = 652032874;
  localparam longint ATAN_TAB [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // Register indexes that map to nothing; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Run shape
  localparam int     RAND_PHASES     = 12;
  localparam int     ITEMS_PER_PHASE = 100;
  localparam int     HOLD_CYCLES     = 300;
  localparam int     DRAIN_CYCLES    = 80;
  localparam longint CYCLE_LIMIT     = 300000;

  typedef struct packed {
    logic [DAC_W-1:0] dac;
    logic [IDX_W-1:0] echo;
    logic             clamp;
  } dac_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_sel;
    logic [CFG_W-1:0]     data;
    logic [IDX_W-1:0]     idx;
    logic                 typed;
    dac_result_t          want;
  } plan_row_t;

  // DUT ports; every input starts at a known value
  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [IDX_W-1:0]     sample_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [DAC_W-1:0]     dac_value_o;
  logic [IDX_W-1:0]     echo_index_o;
  logic                 was_clamped_o;

  // Shadow copy of the configuration registers
  logic signed [AMP_W-1:0] amp_r   = 13'sd1842;
  logic signed [OFF_W-1:0] off_r   = 14'sd2047;
  logic signed [ANG_W-1:0] start_r = 14'sd0;
  logic signed [ANG_W-1:0] end_r   = 14'sd5760;
  logic [CNT_W-1:0]        cnt_r   = 11'd1024;

  dac_result_t dac_expect_q [$];
  plan_row_t   plan [$];

  int     mismatch_cnt = 0;
  int     samples_sent = 0;
  int     results_seen = 0;
  int     clamped_seen = 0;
  int     settings_cnt = 1;
  int     idle_pct     = 0;
  int     stall_pct    = 0;
  logic   hold_kick    = 1'b0;
  logic   hold_seen    = 1'b0;
  int     hold_left    = 0;
  longint cycle_cnt    = 0;

  sine_dac_sample_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_index_i (sample_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dac_value_o    (dac_value_o),
    .echo_index_o   (echo_index_o),
    .was_clamped_o  (was_clamped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Count as the block sees it: zero acts as one, large values saturate
  function automatic longint eff_count();
    longint c;
    c = longint'(cnt_r);
    if (c == 0) c = 1;
    if (c > SAMPLES_CAP) c = SAMPLES_CAP;
    return c;
  endfunction

  // Expected DAC code for one sample index under the shadow configuration
  function automatic dac_result_t predict_dac(input logic [IDX_W-1:0] idx_in);
    longint      cnt, idx, n, num, den, q, x, y, z, xs, ys, s, v;
    logic [31:0] phase, probe;
    logic        neg;
    dac_result_t r;
    cnt = eff_count();
    idx = longint'(idx_in);
    if (idx > cnt - 1) idx = cnt - 1;
    // Phase as a 32-bit binary angle, floor division by count*5760
    n   = longint'(start_r) * cnt + (longint'(end_r) - longint'(start_r)) * idx;
    num = n * 64'sd4294967296;
    den = cnt * TURN;
    q   = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    phase = q[31:0];
    // Fold the back half of the circle onto -90..+90 degrees
    neg   = 1'b0;
    probe = phase + 32'h4000_0000;
    if (probe[31]) begin
      phase = phase + 32'h8000_0000;
      neg   = 1'b1;
    end
    z = longint'($signed(phase));
    x = GAIN_X0;
    y = 0;
    for (int k = 0; k < ROT_STAGES; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[k];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[k];
      end
    end
    s = (y + 16384) >>> 15;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    if (neg) s = -s;
    if (s > 32767) s = 32767;
    // Scale, offset, truncate toward zero, then limit to the DAC range
    v = (longint'(amp_r) * s + longint'(off_r) * 32768) / 32768;
    r.clamp = 1'b0;
    if (v < 0) begin
      v       = 0;
      r.clamp = 1'b1;
    end
    if (v > DAC_TOP) begin
      v       = DAC_TOP;
      r.clamp = 1'b1;
    end
    r.dac  = v[DAC_W-1:0];
    r.echo = idx[IDX_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t wr_row(input logic [CFG_IDX_W-1:0] sel,
                                       input logic [CFG_W-1:0] data);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_WRITE;
    r.reg_sel = sel;
    r.data    = data;
    return r;
  endfunction

  function automatic plan_row_t smp_row(input logic [IDX_W-1:0] idx, input logic typed,
                                        input logic [DAC_W-1:0] dac,
                                        input logic [IDX_W-1:0] echo, input logic clamp);
    plan_row_t r;
    r         = '0;
    r.kind    = ROW_SAMPLE;
    r.idx     = idx;
    r.typed   = typed;
    r.want    = '{dac, echo, clamp};
    return r;
  endfunction

  // Random register value: mostly in range, sometimes an extreme, sometimes raw bits
  function automatic logic [CFG_W-1:0] rand_cfg(input cfg_reg_e sel);
    int unsigned pick;
    int          val;
    pick = $urandom_range(9);
    case (sel)
      CFG_AMPLITUDE: val = (pick == 0) ? -4095 : (pick == 1) ? 4095
                         : int'($urandom_range(8190)) - 4095;
      CFG_DC_OFFSET: val = (pick == 0) ? -4095 : (pick == 1) ? 8191
                         : int'($urandom_range(12286)) - 4095;
      CFG_SAMPLE_COUNT: val = (pick == 0) ? 1 : (pick == 1) ? 1024
                            : (pick == 2) ? int'($urandom_range(16, 1))
                            : int'($urandom_range(1024, 1));
      default: val = (pick == 0) ? -5760 : (pick == 1) ? 5760
                   : int'($urandom_range(11520)) - 5760;
    endcase
    if (pick == 9) val = int'($urandom);
    return val[CFG_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    int unsigned top, pick;
    top  = int'(eff_count()) - 1;
    pick = $urandom_range(19);
    if (pick < 12) return IDX_W'($urandom_range(top));
    if (pick < 15) return IDX_W'($urandom);
    if (pick < 17) return IDX_W'(top);
    if (pick < 18) return '0;
    return '1;
  endfunction

  // Offer one sample after a random gap; log its expectation on transfer
  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic typed,
                             input dac_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    dac_expect_q.push_back(typed ? want : predict_dac(idx));
    samples_sent++;
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (dac_expect_q.size() != 0) @(posedge clk_i);
  endtask

  // Single-cycle register write; update the shadow copy alongside
  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_wdata_i <= data;
    case (sel)
      CFG_AMPLITUDE:    amp_r   = data[AMP_W-1:0];
      CFG_DC_OFFSET:    off_r   = data[OFF_W-1:0];
      CFG_START_ANGLE:  start_r = data[ANG_W-1:0];
      CFG_END_ANGLE:    end_r   = data[ANG_W-1:0];
      CFG_SAMPLE_COUNT: cnt_r   = data[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: check every transfer, then pick the stall for the next cycle.
  // A toggle of hold_kick starts a long hold-off counted here.
  always @(posedge clk_i) begin : result_check
    dac_result_t got, want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      got = '{dac_value_o, echo_index_o, was_clamped_o};
      results_seen++;
      if (got.clamp) clamped_seen++;
      if (dac_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result dac=%0d echo=%0d", got.dac, got.echo));
      end else begin
        want = dac_expect_q.pop_front();
        if (got.dac !== want.dac)
          report_mismatch($sformatf("dac_value %0d, want %0d (echo %0d)",
                                    got.dac, want.dac, want.echo));
        if (got.echo !== want.echo)
          report_mismatch($sformatf("echo_index %0d, want %0d", got.echo, want.echo));
        if (got.clamp !== want.clamp)
          report_mismatch($sformatf("was_clamped %0b, want %0b (echo %0d)",
                                    got.clamp, want.clamp, want.echo));
      end
    end
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
               dac_expect_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_reg_e sel;

    // Directed table: reset values, clamping at both rails, count and index limits,
    // ignored register indexes, angle and amplitude extremes, zero span
    plan.push_back(smp_row(10'd0,    1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd256,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd1023, 1'b0, '0, '0, 1'b0));
    plan.push_back(wr_row(CFG_AMPLITUDE,    14'd0));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'd8191));
    plan.push_back(smp_row(10'd5,    1'b1, 12'd4095, 10'd5,    1'b1));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'(-4095)));
    plan.push_back(smp_row(10'd1023, 1'b1, 12'd0,    10'd1023, 1'b1));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'd4095));
    plan.push_back(wr_row(CFG_SAMPLE_COUNT, 14'd0));
    plan.push_back(smp_row(10'd1023, 1'b1, 12'd4095, 10'd0,    1'b0));
    plan.push_back(wr_row(CFG_SAMPLE_COUNT, 14'd2047));
    plan.push_back(smp_row(10'd1023, 1'b1, 12'd4095, 10'd1023, 1'b0));
    plan.push_back(wr_row(CFG_SAMPLE_COUNT, 14'd1));
    plan.push_back(smp_row(10'd512,  1'b1, 12'd4095, 10'd0,    1'b0));
    plan.push_back(wr_row(CFG_SAMPLE_COUNT, 14'd10));
    plan.push_back(smp_row(10'd700,  1'b1, 12'd4095, 10'd9,    1'b0));
    plan.push_back(wr_row(CFG_SPARE_LO,     14'd0));
    plan.push_back(wr_row(CFG_SPARE_HI,     14'h3FFF));
    plan.push_back(smp_row(10'd3,    1'b1, 12'd4095, 10'd3,    1'b0));
    plan.push_back(wr_row(CFG_AMPLITUDE,    14'd4095));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'd0));
    plan.push_back(wr_row(CFG_START_ANGLE,  14'(-5760)));
    plan.push_back(wr_row(CFG_END_ANGLE,    14'd5760));
    plan.push_back(wr_row(CFG_SAMPLE_COUNT, 14'd1024));
    plan.push_back(smp_row(10'd0,    1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd256,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd512,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd768,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd1023, 1'b0, '0, '0, 1'b0));
    plan.push_back(wr_row(CFG_AMPLITUDE,    14'(-4095)));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'd8191));
    plan.push_back(smp_row(10'd128,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd640,  1'b0, '0, '0, 1'b0));
    // Out-of-range register contents: sign bit of a 13-bit amplitude, wrapped angles
    plan.push_back(wr_row(CFG_AMPLITUDE,    14'h1000));
    plan.push_back(wr_row(CFG_DC_OFFSET,    14'd2047));
    plan.push_back(wr_row(CFG_START_ANGLE,  14'h1FFF));
    plan.push_back(wr_row(CFG_END_ANGLE,    14'h2000));
    plan.push_back(smp_row(10'd0,    1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd300,  1'b0, '0, '0, 1'b0));
    plan.push_back(smp_row(10'd1023, 1'b0, '0, '0, 1'b0));
    plan.push_back(wr_row(CFG_START_ANGLE,  14'd1000));
    plan.push_back(wr_row(CFG_END_ANGLE,    14'd1000));
    plan.push_back(smp_row(10'd77,   1'b0, '0, '0, 1'b0));

    // Hold reset, then release it once
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the table; drain the pipe before each register write
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].reg_sel, plan[i].data);
        settings_cnt++;
      end else begin
        send_sample(plan[i].idx, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: new settings on an idle block, then a burst of samples
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      for (int r = 0; r <= int'(CFG_SAMPLE_COUNT); r++) begin
        sel = cfg_reg_e'(r);
        write_reg(sel, rand_cfg(sel));
      end
      settings_cnt++;
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 53;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 53;
        end
        default: begin
          idle_pct = 23;
          stall_pct <= 23;
        end
      endcase
      // First phase: stall the result side long enough to back up the input
      if (p == 0) hold_kick <= ~hold_kick;
      repeat (ITEMS_PER_PHASE) send_sample(rand_index(), 1'b0, '0);
    end

    // Drain, then give stray results time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (dac_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", dac_expect_q.size()));
    end

    $display("Checked %0d samples across %0d register settings in %0d cycles",
             samples_sent, settings_cnt, cycle_cnt);
    $display("Results: %0d transferred, %0d clamped, %0d mismatches",
             results_seen, clamped_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sine_dac_sample_generator.f
rtl/sdsg_pkg.sv
rtl/sdsg_div_cell.sv
rtl/sdsg_cordic_cell.sv
rtl/sine_dac_sample_generator.sv
sim/sine_dac_sample_generator_tb.sv
